/* rtl/lps_pkg.sv */
// Shared constants, widths and types of the Langevin particle step unit.
package lps_pkg;

    localparam int GRID_DEPTH_DEFAULT = 512;

    // Field widths
    localparam int POS_W       = 24;
    localparam int SCORE_W     = 32;
    localparam int SLOT_W      = 9;
    localparam int GAIN_W      = 31;
    localparam int DT_W        = 24;
    localparam int COUNT_W     = 10;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 31;

    // Grid coordinate: offset (Q4.20) times inverse spacing (Q15.16)
    localparam int COORD_W       = POS_W + GAIN_W;
    localparam int COORD_INT_LSB = 36;
    localparam int COORD_INT_W   = COORD_W - COORD_INT_LSB;
    localparam int WEIGHT_W      = 16;
    localparam int WEIGHT_LSB    = COORD_INT_LSB - WEIGHT_W;

    // Cubic restoring term
    localparam int SQUARE_SHIFT  = 20;
    localparam int SQUARE_W      = 2 * POS_W;
    localparam int SQ_FLOOR_W    = SQUARE_W - SQUARE_SHIFT;
    localparam int CUBE_W        = SQ_FLOOR_W + POS_W;
    localparam int CUBE_SHIFT    = 8;
    localparam int LINEAR_SHIFT  = 12;
    localparam int XTERM_W       = CUBE_W - CUBE_SHIFT + 1;

    // Score interpolation and drift
    localparam int LERP_W        = SCORE_W + 1 + WEIGHT_W + 1;
    localparam int INTERP_W      = LERP_W - WEIGHT_W;
    localparam int GSCORE_W      = 2 * SCORE_W;
    localparam int DRIFT_LO_LSB  = 12;
    localparam int DRIFT_HI_LSB  = DRIFT_LO_LSB + DT_W;
    localparam int DRIFT_HI_W    = GSCORE_W - DRIFT_HI_LSB;
    localparam int DRIFT_LO_W    = DT_W;
    localparam int STEP_HI_W     = DRIFT_HI_W + DT_W + 1;
    localparam int STEP_LO_W     = DRIFT_LO_W + DT_W;
    localparam int STEP_W        = STEP_HI_W;
    localparam int SUM_W         = STEP_W + 2;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_LOWER_BOUND      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_UPPER_BOUND      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_INVERSE_SPACING  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DIFFUSION_GAIN   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_TIME_STEP        = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_GRID_POINTS_USED = 3'd5;

    // Opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    typedef logic signed [POS_W-1:0]   pos_t;
    typedef logic signed [SCORE_W-1:0] score_t;
    typedef logic [SLOT_W-1:0]         slot_t;

    // Reset values of the registers
    localparam pos_t                LOWER_BOUND_RESET      = 24'hD00000;
    localparam pos_t                UPPER_BOUND_RESET      = 24'h300000;
    localparam logic [GAIN_W-1:0]   INVERSE_SPACING_RESET  = 31'd5450411;
    localparam logic [GAIN_W-1:0]   DIFFUSION_GAIN_RESET   = 31'd98304;
    localparam logic [DT_W-1:0]     TIME_STEP_RESET        = 24'd1678;
    localparam logic [COUNT_W-1:0]  GRID_POINTS_USED_RESET = 10'd500;

    localparam pos_t POS_MAX = 24'h7FFFFF;
    localparam pos_t POS_MIN = 24'h800000;

endpackage

/* rtl/lps_if.sv */
// Item and result channels of the Langevin particle step unit.
interface lps_item_if;
    import lps_pkg::*;

    logic   valid;
    logic   ready;
    logic   opcode;
    slot_t  grid_slot;
    score_t score_value;
    pos_t   position;
    pos_t   noise_sample;

    modport source (
        output valid, opcode, grid_slot, score_value, position, noise_sample,
        input  ready
    );
    modport sink (
        input  valid, opcode, grid_slot, score_value, position, noise_sample,
        output ready
    );
endinterface

interface lps_result_if;
    import lps_pkg::*;

    logic  valid;
    logic  ready;
    pos_t  new_position;
    slot_t left_point;
    logic  was_clamped;
    logic  saturated;

    modport source (
        output valid, new_position, left_point, was_clamped, saturated,
        input  ready
    );
    modport sink (
        input  valid, new_position, left_point, was_clamped, saturated,
        output ready
    );
endinterface

/* rtl/lps_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module lps_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 512,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

/* rtl/langevin_particle_step_unit.sv */
// Top level of the Langevin particle step unit: pipelined Euler-Maruyama particle update.
// The unit accepts one transaction per clock while no result is held at the output and
// registers the result of a step item after stage 10; load items write one score entry and
// return nothing. The rate is set by an eleven-stage pipeline around two copies of the score
// row, so that both interpolation neighbors are read in the same cycle from one read port
// each. Loads write both copies in the same stage where steps read them, which keeps loads
// and steps in arrival order without forwarding. When a result is held at the output, the
// whole pipeline and the memory read registers hold. The score row is not cleared after
// reset: a step that reads a grid point never loaded returns an unspecified position. The
// user must write configuration only while no transaction is in flight (not enforced).
module langevin_particle_step_unit #(
    parameter int GRID_DEPTH = lps_pkg::GRID_DEPTH_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [lps_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lps_pkg::CFG_DATA_W-1:0]  cfg_data,
    lps_item_if.sink                       items,
    lps_result_if.source                   results
);
    import lps_pkg::*;

    localparam int ADDR_W = (GRID_DEPTH > 1) ? $clog2(GRID_DEPTH) : 1;

    // Configuration registers
    pos_t               lower_bound_reg;
    pos_t               upper_bound_reg;
    logic [GAIN_W-1:0]  inverse_spacing_reg;
    logic [GAIN_W-1:0]  diffusion_gain_reg;
    logic [DT_W-1:0]    time_step_reg;
    logic [COUNT_W-1:0] grid_points_used_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_bound_reg      <= LOWER_BOUND_RESET;
            upper_bound_reg      <= UPPER_BOUND_RESET;
            inverse_spacing_reg  <= INVERSE_SPACING_RESET;
            diffusion_gain_reg   <= DIFFUSION_GAIN_RESET;
            time_step_reg        <= TIME_STEP_RESET;
            grid_points_used_reg <= GRID_POINTS_USED_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_LOWER_BOUND:      lower_bound_reg      <= cfg_data[POS_W-1:0];
                REG_UPPER_BOUND:      upper_bound_reg      <= cfg_data[POS_W-1:0];
                REG_INVERSE_SPACING:  inverse_spacing_reg  <= cfg_data[GAIN_W-1:0];
                REG_DIFFUSION_GAIN:   diffusion_gain_reg   <= cfg_data[GAIN_W-1:0];
                REG_TIME_STEP:        time_step_reg        <= cfg_data[DT_W-1:0];
                REG_GRID_POINTS_USED: grid_points_used_reg <= cfg_data[COUNT_W-1:0];
                default:              ;
            endcase
        end
    end

    // Pipeline registers
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic s6_valid_reg, s7_valid_reg, s8_valid_reg, s9_valid_reg, s10_valid_reg;
    logic res_valid_reg;

    logic   s1_op_reg, s2_op_reg, s3_op_reg;
    slot_t  s1_slot_reg, s2_slot_reg, s3_slot_reg;
    score_t s1_score_reg, s2_score_reg, s3_score_reg;
    pos_t   s1_pos_reg, s2_pos_reg, s3_pos_reg, s4_pos_reg, s5_pos_reg;
    pos_t   s6_pos_reg, s7_pos_reg, s8_pos_reg, s9_pos_reg, s10_pos_reg;
    pos_t   s1_noise_reg, s2_noise_reg, s3_noise_reg, s4_noise_reg, s5_noise_reg;
    pos_t   s6_noise_reg, s7_noise_reg, s8_noise_reg, s9_noise_reg, s10_noise_reg;
    logic   s2_clamped_reg, s3_clamped_reg, s4_clamped_reg, s5_clamped_reg, s6_clamped_reg;
    logic   s7_clamped_reg, s8_clamped_reg, s9_clamped_reg, s10_clamped_reg;
    logic [ADDR_W-1:0] s4_left_reg, s5_left_reg, s6_left_reg, s7_left_reg;
    logic [ADDR_W-1:0] s8_left_reg, s9_left_reg, s10_left_reg;

    logic [POS_W-1:0]               s2_offset_reg;
    logic [COORD_W-1:0]             s3_coord_reg;
    logic signed [SQUARE_W-1:0]     s3_square_reg;
    logic [WEIGHT_W-1:0]            s4_weight_reg;
    logic signed [CUBE_W-1:0]       s4_cube_reg;
    score_t                         s5_score_left_reg;
    logic signed [LERP_W-1:0]       s5_lerp_reg;
    logic signed [XTERM_W-1:0]      s5_xterm_reg, s6_xterm_reg, s7_xterm_reg;
    score_t                         s6_score_reg;
    logic signed [GSCORE_W-1:0]     s7_gain_score_reg;
    logic signed [DRIFT_HI_W-1:0]   s8_drift_hi_reg;
    logic [DRIFT_LO_W-1:0]          s8_drift_lo_reg;
    logic signed [STEP_HI_W-1:0]    s9_step_hi_reg;
    logic [STEP_LO_W-1:0]           s9_step_lo_reg;
    logic signed [STEP_W-1:0]       s10_step_reg;

    pos_t  res_pos_reg;
    slot_t res_left_reg;
    logic  res_clamped_reg;
    logic  res_sat_reg;

    // Handshake: the pipeline moves whenever the result register is free or being taken
    logic advance;
    assign advance     = !res_valid_reg || results.ready;
    assign items.ready = advance;

    // Stage 1: clamp and grid offset
    pos_t                   pos_raised;
    pos_t                   pos_clamped;
    logic                   clamped_next;
    logic signed [POS_W:0]  offset_diff;
    logic [POS_W-1:0]       offset_next;

    always_comb
    begin
        pos_raised   = (s1_pos_reg < lower_bound_reg) ? lower_bound_reg : s1_pos_reg;
        pos_clamped  = (pos_raised > upper_bound_reg) ? upper_bound_reg : pos_raised;
        clamped_next = (s1_pos_reg < lower_bound_reg) || (pos_raised > upper_bound_reg);
        offset_diff  = {pos_clamped[POS_W-1], pos_clamped}
                     - {lower_bound_reg[POS_W-1], lower_bound_reg};
        // crossed bounds leave a negative offset: pin it to the origin
        offset_next  = offset_diff[POS_W] ? '0 : offset_diff[POS_W-1:0];
    end

    // Stage 2: grid coordinate and square
    logic [COORD_W-1:0]         coord_next;
    logic signed [SQUARE_W-1:0] square_next;

    assign coord_next  = s2_offset_reg * inverse_spacing_reg;
    assign square_next = s2_pos_reg * s2_pos_reg;

    // Stage 3: neighbor selection, score row access, cube
    logic [COORD_INT_W-1:0]       coord_int;
    logic [31:0]                  coord_wide;
    logic [31:0]                  used_minus_one;
    logic [31:0]                  last_point_wide;
    logic                         at_end;
    logic [ADDR_W-1:0]            left_addr;
    logic [ADDR_W-1:0]            right_addr;
    logic [WEIGHT_W-1:0]          weight_next;
    logic signed [SQ_FLOOR_W-1:0] square_floor;
    logic signed [CUBE_W-1:0]     cube_next;
    logic [31:0]                  slot_wide;
    logic                         ram_we;
    logic                         ram_re;
    logic [SCORE_W-1:0]           ram_left_data;
    logic [SCORE_W-1:0]           ram_right_data;

    always_comb
    begin
        coord_int       = s3_coord_reg[COORD_W-1:COORD_INT_LSB];
        coord_wide      = 32'(coord_int);
        used_minus_one  = (grid_points_used_reg == '0) ? 32'd0
                        : 32'(grid_points_used_reg) - 32'd1;
        last_point_wide = (used_minus_one > 32'(GRID_DEPTH - 1)) ? 32'(GRID_DEPTH - 1)
                        : used_minus_one;
        // at the last used point both neighbors collapse onto it
        at_end          = coord_wide >= last_point_wide;
        left_addr       = at_end ? last_point_wide[ADDR_W-1:0] : coord_wide[ADDR_W-1:0];
        right_addr      = at_end ? last_point_wide[ADDR_W-1:0]
                        : coord_wide[ADDR_W-1:0] + ADDR_W'(1);
        weight_next     = at_end ? '0 : s3_coord_reg[COORD_INT_LSB-1:WEIGHT_LSB];
        square_floor    = s3_square_reg[SQUARE_W-1:SQUARE_SHIFT];
        cube_next       = square_floor * s3_pos_reg;
        slot_wide       = 32'(s3_slot_reg);
        ram_we          = advance && s3_valid_reg && (s3_op_reg == OP_LOAD)
                        && (slot_wide < 32'(GRID_DEPTH));
        ram_re          = advance && s3_valid_reg && (s3_op_reg == OP_STEP);
    end

    lps_ram #(
        .WIDTH  (SCORE_W),
        .DEPTH  (GRID_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_row_left (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (slot_wide[ADDR_W-1:0]),
        .wr_data (s3_score_reg),
        .rd_en   (ram_re),
        .rd_addr (left_addr),
        .rd_data (ram_left_data)
    );

    lps_ram #(
        .WIDTH  (SCORE_W),
        .DEPTH  (GRID_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_row_right (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (slot_wide[ADDR_W-1:0]),
        .wr_data (s3_score_reg),
        .rd_en   (ram_re),
        .rd_addr (right_addr),
        .rd_data (ram_right_data)
    );

    // Stage 4: interpolation product and polynomial term
    score_t                     score_left;
    score_t                     score_right;
    logic signed [SCORE_W:0]    score_diff;
    logic signed [LERP_W-1:0]   lerp_next;
    logic signed [XTERM_W-1:0]  cube_term;
    logic signed [XTERM_W-1:0]  linear_term;
    logic signed [XTERM_W-1:0]  xterm_next;

    always_comb
    begin
        score_left  = ram_left_data;
        score_right = ram_right_data;
        score_diff  = {score_right[SCORE_W-1], score_right}
                    - {score_left[SCORE_W-1], score_left};
        lerp_next   = score_diff * $signed({1'b0, s4_weight_reg});
        cube_term   = {s4_cube_reg[CUBE_W-1], s4_cube_reg[CUBE_W-1:CUBE_SHIFT]};
        linear_term = {{(XTERM_W - POS_W - LINEAR_SHIFT){s4_pos_reg[POS_W-1]}},
                       s4_pos_reg, {LINEAR_SHIFT{1'b0}}};
        xterm_next  = cube_term - linear_term;
    end

    // Stage 5: interpolated score
    logic [INTERP_W-1:0] interp_sum;
    score_t              score_next;

    always_comb
    begin
        interp_sum = {{(INTERP_W - SCORE_W){s5_score_left_reg[SCORE_W-1]}}, s5_score_left_reg}
                   + s5_lerp_reg[LERP_W-1:WEIGHT_W];
        score_next = interp_sum[SCORE_W-1:0];
    end

    // Stage 6: diffusion gain times score
    logic signed [GSCORE_W-1:0] gain_score_next;

    assign gain_score_next = $signed({1'b0, diffusion_gain_reg}) * s6_score_reg;

    // Stage 7: drift, split around the dt binary point
    logic [GSCORE_W-1:0] drift_full;

    assign drift_full = s7_gain_score_reg
                      + {{(GSCORE_W - XTERM_W){s7_xterm_reg[XTERM_W-1]}}, s7_xterm_reg};

    // Stage 8: partial products of drift times dt
    logic signed [STEP_HI_W-1:0] step_hi_next;
    logic [STEP_LO_W-1:0]        step_lo_next;

    assign step_hi_next = s8_drift_hi_reg * $signed({1'b0, time_step_reg});
    assign step_lo_next = s8_drift_lo_reg * time_step_reg;

    // Stage 9: floored drift*dt
    logic [STEP_W-1:0] step_next;

    assign step_next = s9_step_hi_reg
                     + {{(STEP_W - (STEP_LO_W - DT_W)){1'b0}}, s9_step_lo_reg[STEP_LO_W-1:DT_W]};

    // Stage 10: sum and saturate
    logic [SUM_W-1:0]       sum_full;
    logic [SUM_W-POS_W:0]   sum_top;
    logic                   sat_next;
    pos_t                   new_pos_next;
    logic [31:0]            left_out_wide;

    always_comb
    begin
        sum_full      = {{(SUM_W - POS_W){s10_pos_reg[POS_W-1]}}, s10_pos_reg}
                      + {{(SUM_W - STEP_W){s10_step_reg[STEP_W-1]}}, s10_step_reg}
                      + {{(SUM_W - POS_W){s10_noise_reg[POS_W-1]}}, s10_noise_reg};
        sum_top       = sum_full[SUM_W-1:POS_W-1];
        sat_next      = !((sum_top == '0) || (sum_top == '1));
        if (!sat_next)
        begin
            new_pos_next = sum_full[POS_W-1:0];
        end
        else if (sum_full[SUM_W-1])
        begin
            new_pos_next = POS_MIN;
        end
        else
        begin
            new_pos_next = POS_MAX;
        end
        left_out_wide = 32'(s10_left_reg);
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            s6_valid_reg  <= 1'b0;
            s7_valid_reg  <= 1'b0;
            s8_valid_reg  <= 1'b0;
            s9_valid_reg  <= 1'b0;
            s10_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= items.valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            // loads end at the score row
            s4_valid_reg  <= s3_valid_reg && (s3_op_reg == OP_STEP);
            s5_valid_reg  <= s4_valid_reg;
            s6_valid_reg  <= s5_valid_reg;
            s7_valid_reg  <= s6_valid_reg;
            s8_valid_reg  <= s7_valid_reg;
            s9_valid_reg  <= s8_valid_reg;
            s10_valid_reg <= s9_valid_reg;
            res_valid_reg <= s10_valid_reg;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_op_reg         <= items.opcode;
            s1_slot_reg       <= items.grid_slot;
            s1_score_reg      <= items.score_value;
            s1_pos_reg        <= items.position;
            s1_noise_reg      <= items.noise_sample;

            s2_op_reg         <= s1_op_reg;
            s2_slot_reg       <= s1_slot_reg;
            s2_score_reg      <= s1_score_reg;
            s2_pos_reg        <= pos_clamped;
            s2_noise_reg      <= s1_noise_reg;
            s2_clamped_reg    <= clamped_next;
            s2_offset_reg     <= offset_next;

            s3_op_reg         <= s2_op_reg;
            s3_slot_reg       <= s2_slot_reg;
            s3_score_reg      <= s2_score_reg;
            s3_pos_reg        <= s2_pos_reg;
            s3_noise_reg      <= s2_noise_reg;
            s3_clamped_reg    <= s2_clamped_reg;
            s3_coord_reg      <= coord_next;
            s3_square_reg     <= square_next;

            s4_weight_reg     <= weight_next;
            s4_left_reg       <= left_addr;
            s4_pos_reg        <= s3_pos_reg;
            s4_noise_reg      <= s3_noise_reg;
            s4_clamped_reg    <= s3_clamped_reg;
            s4_cube_reg       <= cube_next;

            s5_score_left_reg <= score_left;
            s5_lerp_reg       <= lerp_next;
            s5_xterm_reg      <= xterm_next;
            s5_left_reg       <= s4_left_reg;
            s5_pos_reg        <= s4_pos_reg;
            s5_noise_reg      <= s4_noise_reg;
            s5_clamped_reg    <= s4_clamped_reg;

            s6_score_reg      <= score_next;
            s6_xterm_reg      <= s5_xterm_reg;
            s6_left_reg       <= s5_left_reg;
            s6_pos_reg        <= s5_pos_reg;
            s6_noise_reg      <= s5_noise_reg;
            s6_clamped_reg    <= s5_clamped_reg;

            s7_gain_score_reg <= gain_score_next;
            s7_xterm_reg      <= s6_xterm_reg;
            s7_left_reg       <= s6_left_reg;
            s7_pos_reg        <= s6_pos_reg;
            s7_noise_reg      <= s6_noise_reg;
            s7_clamped_reg    <= s6_clamped_reg;

            s8_drift_hi_reg   <= drift_full[GSCORE_W-1:DRIFT_HI_LSB];
            s8_drift_lo_reg   <= drift_full[DRIFT_HI_LSB-1:DRIFT_LO_LSB];
            s8_left_reg       <= s7_left_reg;
            s8_pos_reg        <= s7_pos_reg;
            s8_noise_reg      <= s7_noise_reg;
            s8_clamped_reg    <= s7_clamped_reg;

            s9_step_hi_reg    <= step_hi_next;
            s9_step_lo_reg    <= step_lo_next;
            s9_left_reg       <= s8_left_reg;
            s9_pos_reg        <= s8_pos_reg;
            s9_noise_reg      <= s8_noise_reg;
            s9_clamped_reg    <= s8_clamped_reg;

            s10_step_reg      <= step_next;
            s10_left_reg      <= s9_left_reg;
            s10_pos_reg       <= s9_pos_reg;
            s10_noise_reg     <= s9_noise_reg;
            s10_clamped_reg   <= s9_clamped_reg;

            res_pos_reg       <= new_pos_next;
            res_left_reg      <= left_out_wide[SLOT_W-1:0];
            res_clamped_reg   <= s10_clamped_reg;
            res_sat_reg       <= sat_next;
        end
    end

    assign results.valid        = res_valid_reg;
    assign results.new_position = res_pos_reg;
    assign results.left_point   = res_left_reg;
    assign results.was_clamped  = res_clamped_reg;
    assign results.saturated    = res_sat_reg;

    // A load transaction never produces a result
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> !s4_valid_reg)
        else $error("load transaction entered the result path");

    // Interpolation neighbors are the same point or adjacent points
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |-> ((right_addr == left_addr) || (right_addr == left_addr + ADDR_W'(1))))
        else $error("interpolation neighbors not adjacent");

    // Reads stay within the points in use
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |-> (32'(left_addr) <= last_point_wide))
        else $error("score read beyond last used grid point");

endmodule
